FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define TWCQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// Check that an expression never holds outside reset.
`define TWCQ_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition: label");

`endif

FILE: hw/rtl/twcq_pkg.sv
package twcq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam logic [3:0] BurstReset = 4'd2;
  localparam int CountWidth = 5;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_DONE  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_RD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } fsm_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] client_tag;
    logic        is_preferred;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [31:0]           served_tag;
    logic                  served_preferred;
    logic [CountWidth-1:0] preferred_count;
    logic [CountWidth-1:0] general_count;
  } rsp_t;

endpackage

FILE: hw/rtl/twcq_if.sv
interface twcq_req_if;
  logic             valid;
  logic             ready;
  twcq_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface twcq_rsp_if;
  logic             valid;
  logic             ready;
  twcq_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

FILE: hw/rtl/two_class_weighted_queue.sv
// Channel   | Dir | Transaction
// req_i     | in  | action, client_tag, is_preferred
// rsp_o     | out | status, served_tag, served_preferred, preferred_count, general_count
// apb       | in  | preferred_burst at byte address 0
//
// Enqueue, and dequeue or peek on empty queues, answer from the idle state. Dequeue
// and peek first read the head from the tag memory. Remove reads each entry that it
// searches, then reads and writes each entry moved up, all through the single read port.
// Reset clears fill counts, heads and streak; tag memory is left as is.
// A new request is taken only when the block is idle and the result slot is free
// or being taken; a stalled result holds in the output register.
module two_class_weighted_queue #(
  parameter int QueueDepth = twcq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  twcq_req_if.sink    req_i,
  twcq_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import twcq_pkg::*;

  localparam int IW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int AW = $clog2(2 * QueueDepth);
  localparam logic [IW:0] DepthX = (IW + 1)'(QueueDepth);
  localparam logic [AW-1:0] DepthA = AW'(QueueDepth);
  localparam logic [CW-1:0] DepthC = CW'(QueueDepth);

  // queue 1 is preferred, queue 0 is general
  fsm_e           state_q, state_d;
  logic [IW-1:0]  head_q [2];
  logic [IW-1:0]  head_d [2];
  logic [CW-1:0]  fill_q [2];
  logic [CW-1:0]  fill_d [2];
  logic [3:0]     streak_q, streak_d;
  logic [3:0]     burst_q;
  logic           deq_q, deq_d;
  logic [31:0]    tag_q, tag_d;
  logic           sel_q, sel_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           rsp_valid_q, rsp_valid_d;
  rsp_t           rsp_q, rsp_d;

  logic [31:0]    mem_q [2*QueueDepth];
  logic [31:0]    rd_data_q;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [31:0]    wr_data;

  logic           accept, emit;
  logic [1:0]     emit_status;
  logic [31:0]    emit_tag;
  logic           emit_pref;
  logic           pick_none, pick_sel;
  logic [CW-1:0]  idx_inc;

  function automatic logic [AW-1:0] ent_addr(logic sel, logic [IW-1:0] head,
                                             logic [IW-1:0] ofs);
    logic [IW:0] s;
    s = {1'b0, head} + {1'b0, ofs};
    if (s >= DepthX) begin
      s = s - DepthX;
    end
    return sel ? DepthA + AW'(s[IW-1:0]) : AW'(s[IW-1:0]);
  endfunction

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, burst_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= BurstReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      burst_q <= pwdata[3:0];
    end
  end

  assign req_i.ready   = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;
  assign idx_inc       = idx_q + CW'(1);

  always_comb begin
    pick_none = (fill_q[1] == '0) && (fill_q[0] == '0);
    if ((fill_q[1] != '0) && (streak_q < burst_q)) begin
      pick_sel = 1'b1;
    end else if (fill_q[0] != '0) begin
      pick_sel = 1'b0;
    end else begin
      pick_sel = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    streak_d    = streak_q;
    deq_d       = deq_q;
    tag_d       = tag_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = tag_q;
    emit        = 1'b0;
    emit_status = ST_EMPTY;
    emit_tag    = '0;
    emit_pref   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tag_d = req_i.payload.client_tag;
          case (action_e'(req_i.payload.action))
            ACT_ENQUEUE: begin
              sel_d = req_i.payload.is_preferred;
              emit  = 1'b1;
              if (fill_q[sel_d] >= DepthC) begin
                emit_status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ent_addr(sel_d, head_q[sel_d], fill_q[sel_d][IW-1:0]);
                wr_data = req_i.payload.client_tag;
                fill_d[sel_d] = fill_q[sel_d] + CW'(1);
                emit_status = ST_DONE;
              end
            end
            ACT_DEQUEUE, ACT_PEEK: begin
              deq_d = (req_i.payload.action == ACT_DEQUEUE);
              if (pick_none) begin
                emit = 1'b1;
              end else begin
                sel_d   = pick_sel;
                rd_en   = 1'b1;
                rd_addr = ent_addr(pick_sel, head_q[pick_sel], '0);
                state_d = S_HEAD_RD;
              end
            end
            default: begin
              sel_d   = 1'b1;
              idx_d   = '0;
              state_d = S_SRCH_RD;
            end
          endcase
        end
      end
      S_HEAD_RD: begin
        emit        = 1'b1;
        emit_status = ST_DONE;
        emit_tag    = rd_data_q;
        emit_pref   = sel_q;
        if (deq_q) begin
          head_d[sel_q] = (head_q[sel_q] == IW'(QueueDepth - 1)) ? '0
                          : head_q[sel_q] + IW'(1);
          fill_d[sel_q] = fill_q[sel_q] - CW'(1);
          if (sel_q) begin
            if (streak_q < burst_q) begin
              streak_d = streak_q + 4'd1;
            end
          end else begin
            streak_d = '0;
          end
        end
        state_d = S_IDLE;
      end
      S_SRCH_RD: begin
        if (idx_q == fill_q[sel_q]) begin
          if (sel_q) begin
            sel_d = 1'b0;
            idx_d = '0;
          end else begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = ent_addr(sel_q, head_q[sel_q], idx_q[IW-1:0]);
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rd_data_q == tag_q) begin
          state_d = S_SHIFT_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        // move later entries up one place, then drop the tail
        if (idx_inc < fill_q[sel_q]) begin
          rd_en   = 1'b1;
          rd_addr = ent_addr(sel_q, head_q[sel_q], idx_inc[IW-1:0]);
          state_d = S_SHIFT_WR;
        end else begin
          fill_d[sel_q] = fill_q[sel_q] - CW'(1);
          emit          = 1'b1;
          emit_status   = ST_DONE;
          state_d       = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = ent_addr(sel_q, head_q[sel_q], idx_q[IW-1:0]);
        wr_data = rd_data_q;
        idx_d   = idx_inc;
        state_d = S_SHIFT_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.status           = emit_status;
    rsp_d.served_tag       = emit_tag;
    rsp_d.served_preferred = emit_pref;
    rsp_d.preferred_count  = CountWidth'(fill_d[1]);
    rsp_d.general_count    = CountWidth'(fill_d[0]);
    rsp_valid_d = emit ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      streak_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      streak_q    <= streak_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deq_q <= deq_d;
    tag_q <= tag_d;
    sel_q <= sel_d;
    idx_q <= idx_d;
    if (emit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/twcq_checker.sv
`include "assert_macros.svh"

module twcq_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  twcq_pkg::rsp_t  rsp_payload_i
);
  import twcq_pkg::*;

  logic stall;
  logic empty_rsp;
  logic empty_clean;
  logic pref_rsp;
  logic full_rsp;
  logic both_zero;

  assign stall       = rsp_valid_i && !rsp_ready_i;
  assign empty_rsp   = rsp_valid_i && (rsp_payload_i.status == ST_EMPTY);
  assign empty_clean = (rsp_payload_i.served_tag == '0) && !rsp_payload_i.served_preferred;
  assign pref_rsp    = rsp_valid_i && rsp_payload_i.served_preferred;
  assign full_rsp    = rsp_valid_i && (rsp_payload_i.status == ST_FULL);
  assign both_zero   = (rsp_payload_i.preferred_count == '0) &&
                       (rsp_payload_i.general_count == '0);

  `TWCQ_ASSERT(a_rsp_hold, clk_i, rst_ni, stall |=> rsp_valid_i && $stable(rsp_payload_i))
  `TWCQ_ASSERT(a_empty_zero, clk_i, rst_ni, empty_rsp |-> empty_clean)
  `TWCQ_ASSERT(a_pref_done, clk_i, rst_ni, pref_rsp |-> (rsp_payload_i.status == ST_DONE))
  `TWCQ_NEVER(a_full_empty, clk_i, rst_ni, full_rsp && both_zero)

endmodule

bind two_class_weighted_queue twcq_checker u_twcq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import twcq_pkg::*;

  localparam int Depth = QueueDepthDefault;
  localparam int WatchdogLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  twcq_req_if req_if ();
  twcq_rsp_if rsp_if ();

  two_class_weighted_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the two queues
  logic [31:0] pref_tags[$];
  logic [31:0] gen_tags[$];
  logic [3:0]  streak;
  logic [3:0]  burst;
  rsp_t        expected_rsp[$];

  req_t        pending_req[$];
  logic [31:0] recent_tags[$];
  logic        req_taken = 1'b0;
  logic        hold_off = 1'b0;
  logic        no_idle = 1'b0;
  int          quiet_cycles = 0;
  int          error_count = 0;
  int          rsp_count = 0;
  int          full_drops = 0;
  int          removes_hit = 0;
  int          empty_serves = 0;

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    int   pick;
    bit   hit;
    o = '0;
    hit = 0;
    case (action_e'(r.action))
      ACT_ENQUEUE: begin
        if (r.is_preferred) begin
          if (pref_tags.size() >= Depth) o.status = ST_FULL;
          else begin
            pref_tags.push_back(r.client_tag);
            o.status = ST_DONE;
          end
        end else begin
          if (gen_tags.size() >= Depth) o.status = ST_FULL;
          else begin
            gen_tags.push_back(r.client_tag);
            o.status = ST_DONE;
          end
        end
      end
      ACT_DEQUEUE, ACT_PEEK: begin
        // 0 none, 1 preferred, 2 general
        if (pref_tags.size() == 0 && gen_tags.size() == 0) pick = 0;
        else if (pref_tags.size() != 0 && streak < burst) pick = 1;
        else if (gen_tags.size() != 0) pick = 2;
        else pick = 1;
        if (pick != 0) begin
          o.status = ST_DONE;
          if (pick == 1) begin
            o.served_tag = pref_tags[0];
            o.served_preferred = 1'b1;
          end else begin
            o.served_tag = gen_tags[0];
          end
          if (r.action == ACT_DEQUEUE) begin
            if (pick == 1) begin
              void'(pref_tags.pop_front());
              if (streak < burst) streak = streak + 4'd1;
            end else begin
              void'(gen_tags.pop_front());
              streak = '0;
            end
          end
        end else begin
          o.status = ST_EMPTY;
        end
      end
      default: begin
        for (int i = 0; i < pref_tags.size() && !hit; i++) begin
          if (pref_tags[i] == r.client_tag) begin
            pref_tags.delete(i);
            hit = 1;
          end
        end
        for (int i = 0; i < gen_tags.size() && !hit; i++) begin
          if (gen_tags[i] == r.client_tag) begin
            gen_tags.delete(i);
            hit = 1;
          end
        end
        o.status = hit ? ST_DONE : ST_EMPTY;
      end
    endcase
    o.preferred_count = 5'(pref_tags.size());
    o.general_count = 5'(gen_tags.size());
    return o;
  endfunction

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
  end

  // Request driver
  always @(negedge clk_i) begin
    req_t nxt;
    logic v;
    v = req_if.valid;
    nxt = req_if.payload;
    if (rst_ni && (!v || req_taken)) begin
      if (pending_req.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
        nxt = pending_req.pop_front();
        v = 1'b1;
      end else begin
        v = 1'b0;
      end
    end
    req_if.valid <= v;
    req_if.payload <= nxt;
  end

  // Result receiver
  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && !hold_off && (no_idle || $urandom_range(99) >= 6);
  end

  // Monitor, checker and watchdog
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    req_taken <= req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) burst = pwdata[3:0];
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        rsp_count <= rsp_count + 1;
        if (expected_rsp.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10) $display("ERROR: unexpected result %p", got);
        end else begin
          want = expected_rsp.pop_front();
          if (got.status !== want.status || got.served_tag !== want.served_tag ||
              got.served_preferred !== want.served_preferred ||
              got.preferred_count !== want.preferred_count ||
              got.general_count !== want.general_count) begin
            error_count = error_count + 1;
            if (error_count <= 10)
              $display("ERROR at %0t: expected %p, got %p", $realtime, want, got);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        want = serve_request(req_if.payload);
        if (want.status == ST_FULL) full_drops <= full_drops + 1;
        if (req_if.payload.action == ACT_REMOVE && want.status == ST_DONE)
          removes_hit <= removes_hit + 1;
        if (want.status == ST_EMPTY && req_if.payload.action != ACT_ENQUEUE &&
            req_if.payload.action != ACT_REMOVE)
          empty_serves <= empty_serves + 1;
        expected_rsp.push_back(want);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_req(action_e act, logic [31:0] tag, logic pref);
    req_t r;
    r.action = act;
    r.client_tag = tag;
    r.is_preferred = pref;
    pending_req.push_back(r);
    if (act == ACT_ENQUEUE) begin
      recent_tags.push_back(tag);
      if (recent_tags.size() > 40) void'(recent_tags.pop_front());
    end
  endtask

  task automatic drain();
    while (pending_req.size() != 0 || req_if.valid || expected_rsp.size() != 0)
      @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_burst(logic [3:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= ($urandom & 32'hFFFF_FFF0) | {28'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] random_tag();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return recent_tags.size() != 0 ?
                recent_tags[$urandom_range(recent_tags.size() - 1)] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Random part in runs: fill one class, drain, or mixed traffic
  task automatic random_block(int count);
    int   n;
    int   mode;
    logic cls;
    n = 0;
    while (n < count) begin
      mode = $urandom_range(3);
      cls = 1'($urandom_range(1));
      for (int k = 0; k < 20 && n < count; k++, n++) begin
        case (mode)
          0: add_req(ACT_ENQUEUE, $urandom, ($urandom_range(4) == 0) ? !cls : cls);
          1: add_req(($urandom_range(4) == 0) ? ACT_PEEK : ACT_DEQUEUE, $urandom,
                     1'($urandom_range(1)));
          default: begin
            case ($urandom_range(9))
              0, 1, 2, 3: add_req(ACT_ENQUEUE, random_tag(), 1'($urandom_range(1)));
              4, 5, 6: add_req(ACT_DEQUEUE, random_tag(), 1'($urandom_range(1)));
              7: add_req(ACT_PEEK, random_tag(), 1'($urandom_range(1)));
              default: add_req(ACT_REMOVE, random_tag(), 1'($urandom_range(1)));
            endcase
          end
        endcase
      end
    end
  endtask

  initial begin
    streak = '0;
    burst = BurstReset;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty queues, field extremes, every action
    add_req(ACT_DEQUEUE, 32'h0, 1'b0);
    add_req(ACT_PEEK, 32'hFFFF_FFFF, 1'b1);
    add_req(ACT_REMOVE, 32'h0, 1'b0);
    add_req(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b1);
    add_req(ACT_ENQUEUE, 32'h0, 1'b0);
    add_req(ACT_ENQUEUE, 32'hAAAA_AAAA, 1'b1);
    add_req(ACT_ENQUEUE, 32'h5555_5555, 1'b0);
    add_req(ACT_ENQUEUE, 32'h0, 1'b1);
    add_req(ACT_PEEK, 32'h0, 1'b0);
    add_req(ACT_DEQUEUE, 32'h0, 1'b0);
    add_req(ACT_DEQUEUE, 32'h0, 1'b1);
    add_req(ACT_DEQUEUE, 32'h0, 1'b0);
    add_req(ACT_REMOVE, 32'h0, 1'b1);
    add_req(ACT_REMOVE, 32'h1234_5678, 1'b0);
    add_req(ACT_REMOVE, 32'h5555_5555, 1'b0);
    add_req(ACT_PEEK, 32'h0, 1'b0);
    add_req(ACT_DEQUEUE, 32'h0, 1'b0);
    add_req(ACT_DEQUEUE, 32'h0, 1'b0);

    // Burst of zero: general first
    write_burst(4'd0);
    random_block(200);
    write_burst(4'd15);
    random_block(200);
    // Long receiver stall while requests keep coming
    fork
      random_block(200);
      begin
        repeat (30) @(negedge clk_i);
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join
    write_burst(4'd1);
    // Lower the burst under a running streak without draining the queues
    add_req(ACT_ENQUEUE, $urandom, 1'b1);
    add_req(ACT_ENQUEUE, $urandom, 1'b1);
    add_req(ACT_ENQUEUE, $urandom, 1'b0);
    random_block(150);
    write_burst(4'($urandom_range(15)));
    no_idle = 1'b1;
    random_block(120);
    drain();
    no_idle = 1'b0;
    random_block(150);

    drain();
    repeat (100) @(negedge clk_i);
    $display("Checked %0d results over bursts 0, 1, 2, 15 and one random setting.",
             rsp_count);
    $display("Full-queue drops: %0d, remove hits: %0d, empty serves: %0d.",
             full_drops, removes_hit, empty_serves);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, results still expected: %0d", error_count,
               expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
